[rtl/lrt_pkg.sv]
// Package for the linear regression trainer: shared types, widths, codes
// and saturation helpers. No dependencies.
package lrt_pkg;

   localparam int FEAT_W   = 18;
   localparam int NUM_FEAT = 5;
   localparam int COEF_W   = 32;
   localparam int IDX_W    = 3;
   localparam int OPA_W    = 33;
   localparam int OPB_W    = 18;
   localparam int PROD_W   = OPA_W + OPB_W;
   localparam int ACC_W    = 64;
   localparam int CFG_W    = 16;
   localparam int ADDR_W   = 4;

   localparam logic signed [FEAT_W-1:0] ONE_Q16 = 18'sd65536;

   typedef struct packed {
      logic [NUM_FEAT*FEAT_W-1:0] feats;
      logic [FEAT_W-1:0]          target;
   } sample_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_TRAIN   = 2'd1,
      OP_PREDICT = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_LEARNING_RATE  = 2'd0,
      REG_TOLERANCE      = 2'd1,
      REG_MAX_ITERATIONS = 2'd2,
      REG_NONE           = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_DOT,
      PH_GRAD,
      PH_STEP
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [IDX_W-1:0]   idx;
   } mac_tag_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ITER,
      ST_SAMP,
      ST_RD,
      ST_DOT,
      ST_DOT_WAIT,
      ST_HRES,
      ST_GRAD,
      ST_UPD,
      ST_UPD_WAIT,
      ST_EMIT
   } state_type;

   // Clamp a signed 64-bit value into signed 32 bits
   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[COEF_W-1:0];
   endfunction

endpackage

[rtl/lrt_sample_mem.sv]
// Sample memory of the trainer: one row of five features and a target per sample.
// Depends on lrt_pkg.
module lrt_sample_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  lrt_pkg::sample_type wdata,
   input  logic               ren,
   input  logic [AW-1:0]      raddr,
   output lrt_pkg::sample_type rdata
);
   import lrt_pkg::*;

   sample_type mem [DEPTH];
   sample_type rdata_ff;

   // Write one row
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/lrt_mac.sv]
// Shared signed multiplier of the trainer with a registered product and tag.
// Depends on lrt_pkg.
module lrt_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                mul_en,
   input  logic signed [lrt_pkg::OPA_W-1:0]    op_a,
   input  logic signed [lrt_pkg::OPB_W-1:0]    op_b,
   input  lrt_pkg::mac_tag_type                tag_in,
   output logic                                prod_vld,
   output logic signed [lrt_pkg::PROD_W-1:0]   prod,
   output lrt_pkg::mac_tag_type                tag_out
);
   import lrt_pkg::*;

   logic                       vld_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   mac_tag_type                tag_ff;

   assign prod_in = op_a * op_b;

   // Track which operations are in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= mul_en;
      end
   end

   // Hold product and tag
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
         tag_ff  <= tag_in;
      end
   end

   assign prod_vld = vld_ff;
   assign prod     = prod_ff;
   assign tag_out  = tag_ff;

endmodule

[rtl/linear_regression_trainer_unit.sv]
// Linear regression trainer: batch gradient descent over stored samples.
// Load and clear are accepted back to back; predict and train hold off new requests
// until their results are emitted, and all products go through the single shared
// multiplier. Reset (synchronous) clears samples count, coefficients, flags and
// restores the register defaults; the sample memory holds no reset value.
module linear_regression_trainer_unit #(
   parameter int MAX_SAMPLES = 256,
   parameter int NUM_COEFFS  = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic signed [lrt_pkg::FEAT_W-1:0] req_target,
   input  logic signed [lrt_pkg::FEAT_W-1:0] req_feature_1,
   input  logic signed [lrt_pkg::FEAT_W-1:0] req_feature_2,
   input  logic signed [lrt_pkg::FEAT_W-1:0] req_feature_3,
   input  logic signed [lrt_pkg::FEAT_W-1:0] req_feature_4,
   input  logic signed [lrt_pkg::FEAT_W-1:0] req_feature_5,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_kind,
   output logic [lrt_pkg::IDX_W-1:0]         rsp_coefficient_index,
   output logic signed [lrt_pkg::COEF_W-1:0] rsp_value,
   output logic                              rsp_converged,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lrt_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import lrt_pkg::*;

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CI_W  = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
   localparam logic [IDX_W-1:0]     LAST_J = IDX_W'(NUM_COEFFS - 1);
   localparam logic [NUM_COEFFS-1:0] FULL  = '1;

   // Configuration registers
   logic [CFG_W-1:0] lr_ff, tol_ff, max_it_ff;
   reg_index_type    csr_idx;
   logic             csr_wr;

   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff     <= 16'd3277;
         tol_ff    <= 16'd3277;
         max_it_ff <= 16'd1000;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LEARNING_RATE:  lr_ff     <= csr_pwdata[CFG_W-1:0];
            REG_TOLERANCE:      tol_ff    <= csr_pwdata[CFG_W-1:0];
            REG_MAX_ITERATIONS: max_it_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_LEARNING_RATE:  csr_prdata = {16'd0, lr_ff};
         REG_TOLERANCE:      csr_prdata = {16'd0, tol_ff};
         REG_MAX_ITERATIONS: csr_prdata = {16'd0, max_it_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // Sequencer and datapath state
   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [CNT_W-1:0]           s_ff, s_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CFG_W-1:0]           iter_ff, iter_in;
   logic                       pred_mode_ff, pred_mode_in;
   logic [NUM_FEAT*FEAT_W-1:0] pred_feats_ff;
   logic signed [ACC_W-1:0]    dot_ff;
   logic signed [ACC_W-1:0]    grad_ff [NUM_COEFFS];
   logic signed [COEF_W-1:0]   theta_ff [NUM_COEFFS];
   logic signed [OPA_W-1:0]    resid_ff;
   logic signed [COEF_W-1:0]   pred_val_ff;
   logic [NUM_COEFFS-1:0]      flags_ff;
   logic                       all_conv_ff;

   logic                       req_acc;
   opcode_type                 op;
   logic                       mem_we, mem_ren;
   sample_type                 mem_wdata, mem_rdata;
   logic [NUM_FEAT*FEAT_W-1:0] feats_sel;
   logic signed [FEAT_W-1:0]   feat_cur;

   logic                       mul_en;
   logic signed [OPA_W-1:0]    op_a;
   logic signed [OPB_W-1:0]    op_b;
   mac_tag_type                tag_in, tag_out;
   logic                       mac_vld;
   logic signed [PROD_W-1:0]   prod;

   logic [IDX_W-1:0]           th_idx, gr_idx;
   logic signed [COEF_W-1:0]   theta_rd;
   logic signed [ACC_W-1:0]    grad_rd;
   logic signed [COEF_W-1:0]   h_val, g_val, next_val;
   logic signed [35:0]         step_sum;
   logic signed [OPA_W-1:0]    diff;
   logic [OPA_W-1:0]           mag;
   logic                       emit_go;

   logic                       rsp_valid_ff;
   logic                       rsp_kind_ff, rsp_conv_ff, rsp_last_ff;
   logic [IDX_W-1:0]           rsp_idx_ff;
   logic signed [COEF_W-1:0]   rsp_value_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign op        = opcode_type'(req_opcode);

   assign mem_wdata.feats  = {req_feature_5, req_feature_4, req_feature_3,
                              req_feature_2, req_feature_1};
   assign mem_wdata.target = req_target;

   lrt_sample_mem #(
      .DEPTH (MAX_SAMPLES),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (mem_wdata),
      .ren   (mem_ren),
      .raddr (s_ff[AW-1:0]),
      .rdata (mem_rdata)
   );

   // Pick feature j of the current row; bias is one, missing features are zero
   assign feats_sel = pred_mode_ff ? pred_feats_ff : mem_rdata.feats;
   always_comb begin
      feat_cur = '0;
      if (j_ff == '0) begin
         feat_cur = ONE_Q16;
      end
      for (int k = 0; k < NUM_FEAT; k++) begin
         if (j_ff == IDX_W'(k + 1)) begin
            feat_cur = feats_sel[k*FEAT_W +: FEAT_W];
         end
      end
   end

   // Single read port on coefficients and gradients: landing product wins
   assign th_idx   = (mac_vld && tag_out.phase == PH_STEP) ? tag_out.idx : j_ff;
   assign gr_idx   = (mac_vld && tag_out.phase == PH_GRAD) ? tag_out.idx : j_ff;
   assign theta_rd = theta_ff[th_idx[CI_W-1:0]];
   assign grad_rd  = grad_ff[gr_idx[CI_W-1:0]];

   assign h_val    = sat32(dot_ff >>> 16);
   assign g_val    = sat32(grad_rd >>> 16);
   assign step_sum = 36'(theta_rd) + 36'($signed(prod[PROD_W-1:16]));
   assign next_val = sat32(ACC_W'(step_sum));
   assign diff     = OPA_W'(next_val) - OPA_W'(theta_rd);
   assign mag      = diff[OPA_W-1] ? OPA_W'(-diff) : OPA_W'(diff);

   assign emit_go  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // Next state, counters and multiplier operands
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      s_in         = s_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      pred_mode_in = pred_mode_ff;
      mem_we       = 1'b0;
      mem_ren      = 1'b0;
      mul_en       = 1'b0;
      op_a         = '0;
      op_b         = '0;
      tag_in.phase = PH_DOT;
      tag_in.idx   = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op)
                  OP_LOAD: begin
                     if (count_ff < CNT_W'(MAX_SAMPLES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: count_in = '0;
                  OP_PREDICT: begin
                     pred_mode_in = 1'b1;
                     j_in         = '0;
                     state_in     = ST_DOT;
                  end
                  default: begin
                     pred_mode_in = 1'b0;
                     iter_in      = '0;
                     state_in     = ST_ITER;
                  end
               endcase
            end
         end
         ST_ITER: begin
            if (iter_ff >= max_it_ff || flags_ff == FULL) begin
               j_in     = '0;
               state_in = ST_EMIT;
            end else begin
               s_in     = '0;
               state_in = ST_SAMP;
            end
         end
         ST_SAMP: begin
            j_in = '0;
            if (s_ff == count_ff) begin
               state_in = ST_UPD;
            end else begin
               mem_ren  = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            j_in     = '0;
            state_in = ST_DOT;
         end
         ST_DOT: begin
            mul_en = 1'b1;
            op_a   = OPA_W'(theta_rd);
            op_b   = feat_cur;
            if (j_ff == LAST_J) begin
               state_in = ST_DOT_WAIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DOT_WAIT: state_in = ST_HRES;
         ST_HRES: begin
            j_in     = '0;
            state_in = pred_mode_ff ? ST_EMIT : ST_GRAD;
         end
         ST_GRAD: begin
            mul_en       = 1'b1;
            op_a         = resid_ff;
            op_b         = feat_cur;
            tag_in.phase = PH_GRAD;
            if (j_ff == LAST_J) begin
               s_in     = s_ff + 1'b1;
               state_in = ST_SAMP;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_UPD: begin
            mul_en       = 1'b1;
            op_a         = OPA_W'(g_val);
            op_b         = {2'b00, lr_ff};
            tag_in.phase = PH_STEP;
            if (j_ff == LAST_J) begin
               state_in = ST_UPD_WAIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_UPD_WAIT: begin
            iter_in  = iter_ff + 1'b1;
            state_in = ST_ITER;
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (pred_mode_ff || j_ff == LAST_J) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pred_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pred_mode_ff <= pred_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      s_ff    <= s_in;
      iter_ff <= iter_in;
   end

   lrt_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .mul_en   (mul_en),
      .op_a     (op_a),
      .op_b     (op_b),
      .tag_in   (tag_in),
      .prod_vld (mac_vld),
      .prod     (prod),
      .tag_out  (tag_out)
   );

   // Dot product accumulator, residual and prediction
   always_ff @(posedge clock) begin
      if (req_acc && op == OP_PREDICT) begin
         pred_feats_ff <= mem_wdata.feats;
      end
      if ((req_acc && op == OP_PREDICT) || state_ff == ST_RD) begin
         dot_ff <= '0;
      end else if (mac_vld && tag_out.phase == PH_DOT) begin
         dot_ff <= dot_ff + ACC_W'(prod);
      end
      if (state_ff == ST_HRES) begin
         pred_val_ff <= h_val;
         resid_ff    <= OPA_W'($signed(mem_rdata.target)) - OPA_W'(h_val);
      end
   end

   // Gradient accumulators, cleared at the start of each iteration
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_COEFFS; k++) begin
         if (state_ff == ST_ITER) begin
            grad_ff[k] <= '0;
         end else if (mac_vld && tag_out.phase == PH_GRAD && gr_idx == IDX_W'(k)) begin
            grad_ff[k] <= grad_rd + ACC_W'(prod);
         end
      end
   end

   // Coefficients and sticky convergence flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEFFS; k++) begin
            theta_ff[k] <= '0;
         end
         flags_ff    <= '0;
         all_conv_ff <= 1'b0;
      end else begin
         if (req_acc && op == OP_TRAIN) begin
            for (int k = 0; k < NUM_COEFFS; k++) begin
               theta_ff[k] <= '0;
            end
            flags_ff <= '0;
         end else if (mac_vld && tag_out.phase == PH_STEP) begin
            theta_ff[th_idx[CI_W-1:0]] <= next_val;
            if (mag < OPA_W'(tol_ff)) begin
               flags_ff[th_idx[CI_W-1:0]] <= 1'b1;
            end
         end
         if (state_ff == ST_ITER && state_in == ST_EMIT) begin
            all_conv_ff <= (flags_ff == FULL);
         end
      end
   end

   // Output register: hold a result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_kind_ff  <= pred_mode_ff;
         rsp_idx_ff   <= pred_mode_ff ? '0 : j_ff;
         rsp_value_ff <= pred_mode_ff ? pred_val_ff : theta_rd;
         rsp_conv_ff  <= all_conv_ff;
         rsp_last_ff  <= pred_mode_ff || (j_ff == LAST_J);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_coefficient_index = rsp_idx_ff;
   assign rsp_value             = rsp_value_ff;
   assign rsp_converged         = rsp_conv_ff;
   assign rsp_last              = rsp_last_ff;

   // Sample count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above capacity");

   // No product in flight while a new request can be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mac_vld)
      else $error("multiplier busy while idle");

   // A prediction is a single result at index zero
   a_pred_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_last && rsp_coefficient_index == '0))
      else $error("prediction result malformed");

   // Coefficient steps land only in the cycle after an update issue
   a_step_origin: assert property (@(posedge clock) disable iff (reset)
      (mac_vld && tag_out.phase == PH_STEP) |-> $past(state_ff) == ST_UPD)
      else $error("coefficient step outside update phase");

endmodule
